// File: rtl/sadc_pkg.sv
// sadc_pkg: shared types, widths and codes for the serial adc frame reader
// no dependencies; used by the result and config channel interfaces and the top level
`default_nettype none

package sadc_pkg;

    // frame length and derived widths
    localparam int DATA_BITS = 24;
    localparam int BIT_CNT_W = $clog2(DATA_BITS);
    localparam int SAMPLE_W  = 24;
    localparam int HALF_W    = 16;
    localparam int WAIT_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    typedef logic [1:0]               t_status;
    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [BIT_CNT_W-1:0]     t_bit_cnt;
    typedef logic [DATA_BITS-1:0]     t_frame;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [CFG_DAT_W-1:0]     t_cfg_dat;

    // index of the last frame bit, loaded into the bit counter
    localparam t_bit_cnt BIT_LAST = t_bit_cnt'(DATA_BITS - 1);

    // result status codes
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_TIMEOUT = 2'd1;
    localparam t_status ST_ALLONES = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx REG_TIMEOUT = 2'd0;
    localparam t_cfg_idx REG_HALF    = 2'd1;
    localparam t_cfg_idx REG_POWER   = 2'd2;
    localparam t_cfg_idx REG_CHANNEL = 2'd3;

    // configuration reset values
    localparam logic [WAIT_W-1:0] RST_TIMEOUT = 32'd100000;
    localparam logic [HALF_W-1:0] RST_HALF    = 16'd2;

endpackage

`default_nettype wire

// File: rtl/sadc_in_if.sv
// sadc_in_if: tick item channel (request and sampled data line)
// depends on nothing
`default_nettype none

interface sadc_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic dout;

    modport source (output valid, output start_req, output dout, input ready);
    modport sink   (input valid, input start_req, input dout, output ready);
endinterface

`default_nettype wire

// File: rtl/sadc_out_if.sv
// sadc_out_if: per-tick result channel (pin levels and read outcome)
// depends on sadc_pkg for the status and sample types
`default_nettype none

interface sadc_out_if;
    logic              valid;
    logic              ready;
    logic              sclk;
    logic              busy_res;
    logic              done_res;
    sadc_pkg::t_status status;
    sadc_pkg::t_sample sample;
    logic              pdwn_level;
    logic              a0_level;

    modport source (output valid, output sclk, output busy_res, output done_res,
                    output status, output sample, output pdwn_level,
                    output a0_level, input ready);
    modport sink   (input valid, input sclk, input busy_res, input done_res,
                    input status, input sample, input pdwn_level,
                    input a0_level, output ready);
endinterface

`default_nettype wire

// File: rtl/sadc_cfg_if.sv
// sadc_cfg_if: configuration write channel (register index and data)
// depends on sadc_pkg for the index and data types
`default_nettype none

interface sadc_cfg_if;
    logic               valid;
    logic               ready;
    sadc_pkg::t_cfg_idx index;
    sadc_pkg::t_cfg_dat data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/serial_adc_frame_reader.sv
// serial_adc_frame_reader: pin sequencer for a serial adc with shared data/ready line
// depends on sadc_pkg, sadc_in_if, sadc_out_if and sadc_cfg_if
//
//   channel    dir  handshake     payload
//   i_item     in   valid/ready   start_req, dout
//   o_result   out  valid/ready   sclk, busy_res, done_res, status, sample,
//                                 pdwn_level, a0_level
//   i_cfg      in   valid/ready   index, data (always ready)
//
// one result per item; the result is registered and appears in the cycle after the item is taken
// an item is taken every cycle while the result register is empty or drained
// the rate is set by the single result register between sequencer and sink
// i_rst_n (synchronous, active low) clears the sequencer and loads config defaults
// a stalled sink holds the result and stops further items until it is taken
`default_nettype none

module serial_adc_frame_reader (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sadc_in_if.sink    i_item,
    sadc_out_if.source o_result,
    sadc_cfg_if.sink   i_cfg
);

    // sequencer phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_WAIT     = 3'd1;
    localparam logic [2:0] PH_HIGH     = 3'd2;
    localparam logic [2:0] PH_LOW      = 3'd3;
    localparam logic [2:0] PH_SETTLE_H = 3'd4;
    localparam logic [2:0] PH_SETTLE_L = 3'd5;

    // configuration registers
    logic [sadc_pkg::WAIT_W-1:0] r_timeout;
    logic [sadc_pkg::HALF_W-1:0] r_half_period;
    logic                        r_power_en;
    logic                        r_chan_sel;

    // sequencer state
    logic [2:0]                  r_phase,    n_phase;
    sadc_pkg::t_bit_cnt          r_bit_cnt,  n_bit_cnt;
    logic [sadc_pkg::HALF_W-1:0] r_half_cnt, n_half_cnt;
    logic [sadc_pkg::WAIT_W-1:0] r_wait_cnt, n_wait_cnt;
    sadc_pkg::t_frame            r_shift,    n_shift;

    // result register
    logic              r_out_valid;
    logic              r_sclk,  n_sclk;
    logic              r_busy,  n_busy;
    logic              r_done,  n_done;
    sadc_pkg::t_status r_status, n_status;
    sadc_pkg::t_sample r_sample, n_sample;
    logic              r_pdwn;
    logic              r_a0;

    logic                        accept;
    logic [sadc_pkg::HALF_W-1:0] half_len;
    logic [sadc_pkg::HALF_W:0]   half_next;
    logic                        half_end;

    // handshakes
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;

    // config writes, unknown indexes fall through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= sadc_pkg::RST_TIMEOUT;
            r_half_period <= sadc_pkg::RST_HALF;
            r_power_en    <= 1'b1;
            r_chan_sel    <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                sadc_pkg::REG_TIMEOUT: r_timeout     <= i_cfg.data;
                sadc_pkg::REG_HALF:    r_half_period <= i_cfg.data[sadc_pkg::HALF_W-1:0];
                sadc_pkg::REG_POWER:   r_power_en    <= i_cfg.data[0];
                sadc_pkg::REG_CHANNEL: r_chan_sel    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // end of a clock half, zero period behaves as one tick
    assign half_len  = (r_half_period == '0) ? sadc_pkg::HALF_W'(1) : r_half_period;
    assign half_next = {1'b0, r_half_cnt} + (sadc_pkg::HALF_W + 1)'(1);
    assign half_end  = half_next >= {1'b0, half_len};

    // next state and result for one tick
    always_comb begin
        n_phase    = r_phase;
        n_bit_cnt  = r_bit_cnt;
        n_half_cnt = r_half_cnt;
        n_wait_cnt = r_wait_cnt;
        n_shift    = r_shift;
        n_sclk     = 1'b0;
        n_busy     = 1'b0;
        n_done     = 1'b0;
        n_status   = sadc_pkg::ST_OK;
        n_sample   = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.start_req) begin
                    n_phase    = PH_WAIT;
                    n_wait_cnt = '0;
                end
            end
            PH_WAIT: begin
                n_busy = 1'b1;
                if (!i_item.dout) begin
                    n_phase    = PH_HIGH;
                    n_half_cnt = '0;
                    n_bit_cnt  = sadc_pkg::BIT_LAST;
                    n_shift    = '0;
                end else if (r_wait_cnt >= r_timeout) begin
                    n_done   = 1'b1;
                    n_status = sadc_pkg::ST_TIMEOUT;
                    n_phase  = PH_IDLE;
                end else begin
                    n_wait_cnt = r_wait_cnt + sadc_pkg::WAIT_W'(1);
                end
            end
            PH_HIGH: begin
                n_busy     = 1'b1;
                n_sclk     = 1'b1;
                n_half_cnt = half_end ? '0 : half_next[sadc_pkg::HALF_W-1:0];
                if (half_end) begin
                    n_shift = {r_shift[sadc_pkg::DATA_BITS-2:0], i_item.dout};
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_busy     = 1'b1;
                n_half_cnt = half_end ? '0 : half_next[sadc_pkg::HALF_W-1:0];
                if (half_end) begin
                    if (r_bit_cnt == '0) begin
                        n_phase = PH_SETTLE_H;
                    end else begin
                        n_bit_cnt = r_bit_cnt - sadc_pkg::BIT_CNT_W'(1);
                        n_phase   = PH_HIGH;
                    end
                end
            end
            PH_SETTLE_H: begin
                n_busy     = 1'b1;
                n_sclk     = 1'b1;
                n_half_cnt = half_end ? '0 : half_next[sadc_pkg::HALF_W-1:0];
                if (half_end) begin
                    n_phase = PH_SETTLE_L;
                end
            end
            PH_SETTLE_L: begin
                n_busy     = 1'b1;
                n_half_cnt = half_end ? '0 : half_next[sadc_pkg::HALF_W-1:0];
                if (half_end) begin
                    n_done  = 1'b1;
                    n_phase = PH_IDLE;
                    if (&r_shift) begin
                        n_status = sadc_pkg::ST_ALLONES;
                    end else begin
                        // cast the frame to the signed sample type; both are 24 bits wide
                        n_sample = sadc_pkg::t_sample'($signed(r_shift));
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // sequencer state advances on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_bit_cnt  <= '0;
            r_half_cnt <= '0;
            r_wait_cnt <= '0;
            r_shift    <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_bit_cnt  <= n_bit_cnt;
            r_half_cnt <= n_half_cnt;
            r_wait_cnt <= n_wait_cnt;
            r_shift    <= n_shift;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sclk   <= n_sclk;
            r_busy   <= n_busy;
            r_done   <= n_done;
            r_status <= n_status;
            r_sample <= n_sample;
            r_pdwn   <= r_power_en;
            r_a0     <= r_chan_sel;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.sclk       = r_sclk;
    assign o_result.busy_res   = r_busy;
    assign o_result.done_res   = r_done;
    assign o_result.status     = r_status;
    assign o_result.sample     = r_sample;
    assign o_result.pdwn_level = r_pdwn;
    assign o_result.a0_level   = r_a0;

    // a taken item always leaves a result behind
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("taken item produced no result");

    // a finished read always comes from a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_busy)
        else $error("done without busy");

    // error status only on a finishing tick
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != sadc_pkg::ST_OK)) |-> r_done)
        else $error("status set outside a finishing tick");

    // sample only on a good finish
    a_sample_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_sample != '0)) |-> (r_done && (r_status == sadc_pkg::ST_OK)))
        else $error("sample driven without a good frame");

    // clock pulses only during a read
    a_sclk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_sclk) |-> r_busy)
        else $error("clock pulse while not busy");

endmodule

`default_nettype wire

// File: test/tb_serial_adc_frame_reader.sv
// tb_serial_adc_frame_reader: self-checking bench for the serial adc frame reader
// depends on sadc_pkg, sadc_in_if, sadc_out_if, sadc_cfg_if and serial_adc_frame_reader
// ticks are predicted by a local pin sequencer model and every result is checked in order
`default_nettype none

module tb_serial_adc_frame_reader;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_WAIT,
        SEQ_CLK_HI,
        SEQ_CLK_LO,
        SEQ_SETTLE_HI,
        SEQ_SETTLE_LO
    } t_seq_phase;

    typedef struct packed {
        logic start_req;
        logic dout;
    } t_tick_item;

    typedef struct packed {
        logic              sclk;
        logic              busy;
        logic              done;
        sadc_pkg::t_status status;
        sadc_pkg::t_sample sample;
        logic              pdwn;
        logic              a0;
    } t_pin_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sadc_in_if  item_if ();
    sadc_out_if result_if ();
    sadc_cfg_if cfg_if ();

    serial_adc_frame_reader u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .i_cfg    (cfg_if)
    );

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies held by the sequencer model
    logic [sadc_pkg::WAIT_W-1:0] cfg_timeout = sadc_pkg::RST_TIMEOUT;
    logic [sadc_pkg::HALF_W-1:0] cfg_half    = sadc_pkg::RST_HALF;
    logic                        cfg_power   = 1'b1;
    logic                        cfg_channel = 1'b0;

    // sequencer model state
    t_seq_phase                  seq_phase = SEQ_IDLE;
    sadc_pkg::t_bit_cnt          bit_cnt   = '0;
    logic [sadc_pkg::HALF_W-1:0] half_cnt  = '0;
    logic [sadc_pkg::WAIT_W-1:0] wait_cnt  = '0;
    sadc_pkg::t_frame            shift_reg = '0;

    t_tick_item  pending_ticks[$];
    t_pin_result expected_pins[$];

    int unsigned send_idle_pct    = 0;
    int unsigned recv_stall_pct   = 0;
    int unsigned ticks_queued     = 0;
    int unsigned ticks_open       = 0;
    int unsigned ticks_checked    = 0;
    int unsigned mismatch_count   = 0;
    int unsigned frames_good      = 0;
    int unsigned frames_timeout   = 0;
    int unsigned frames_allones   = 0;
    int unsigned settings_run     = 0;

    // advance the half-period counter, 1 on the last tick of a half
    function automatic logic half_tick_end();
        logic [sadc_pkg::HALF_W:0] len;
        len = (cfg_half == '0) ? (sadc_pkg::HALF_W + 1)'(1) : {1'b0, cfg_half};
        if ({1'b0, half_cnt} + (sadc_pkg::HALF_W + 1)'(1) >= len) begin
            half_cnt = '0;
            return 1'b1;
        end
        half_cnt = half_cnt + sadc_pkg::HALF_W'(1);
        return 1'b0;
    endfunction

    // one tick of the pin sequencer
    function automatic t_pin_result predict_tick(input logic start, input logic line);
        t_pin_result r;
        r = '0;
        r.status = sadc_pkg::ST_OK;
        case (seq_phase)
            SEQ_IDLE: begin
                if (start) begin
                    seq_phase = SEQ_WAIT;
                    wait_cnt  = '0;
                end
            end
            SEQ_WAIT: begin
                r.busy = 1'b1;
                if (!line) begin
                    seq_phase = SEQ_CLK_HI;
                    half_cnt  = '0;
                    bit_cnt   = sadc_pkg::BIT_LAST;
                    shift_reg = '0;
                end else if (wait_cnt >= cfg_timeout) begin
                    r.done    = 1'b1;
                    r.status  = sadc_pkg::ST_TIMEOUT;
                    seq_phase = SEQ_IDLE;
                end else begin
                    wait_cnt = wait_cnt + sadc_pkg::WAIT_W'(1);
                end
            end
            SEQ_CLK_HI: begin
                r.busy = 1'b1;
                r.sclk = 1'b1;
                if (half_tick_end()) begin
                    shift_reg = {shift_reg[sadc_pkg::DATA_BITS-2:0], line};
                    seq_phase = SEQ_CLK_LO;
                end
            end
            SEQ_CLK_LO: begin
                r.busy = 1'b1;
                if (half_tick_end()) begin
                    if (bit_cnt == '0) begin
                        seq_phase = SEQ_SETTLE_HI;
                    end else begin
                        bit_cnt   = bit_cnt - sadc_pkg::BIT_CNT_W'(1);
                        seq_phase = SEQ_CLK_HI;
                    end
                end
            end
            SEQ_SETTLE_HI: begin
                r.busy = 1'b1;
                r.sclk = 1'b1;
                if (half_tick_end()) seq_phase = SEQ_SETTLE_LO;
            end
            SEQ_SETTLE_LO: begin
                r.busy = 1'b1;
                if (half_tick_end()) begin
                    r.done    = 1'b1;
                    seq_phase = SEQ_IDLE;
                    if (&shift_reg) begin
                        r.status = sadc_pkg::ST_ALLONES;
                    end else begin
                        r.sample = sadc_pkg::t_sample'($signed(shift_reg));
                    end
                end
            end
            default: seq_phase = SEQ_IDLE;
        endcase
        r.pdwn = cfg_power;
        r.a0   = cfg_channel;
        return r;
    endfunction

    function automatic string fmt_pins(input t_pin_result r);
        return $sformatf("sclk=%0b busy=%0b done=%0b status=%0d sample=%0d pdwn=%0b a0=%0b",
                         r.sclk, r.busy, r.done, r.status, r.sample, r.pdwn, r.a0);
    endfunction

    // item driver: predicts each accepted tick, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                expected_pins.push_back(predict_tick(item_if.start_req, item_if.dout));
            end
            if (!item_if.valid || item_if.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    item_if.valid     <= 1'b1;
                    item_if.start_req <= pending_ticks[0].start_req;
                    item_if.dout      <= pending_ticks[0].dout;
                    void'(pending_ticks.pop_front());
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_pin_result got;
        t_pin_result want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (result_if.valid && result_if.ready) begin
                got = '{sclk: result_if.sclk, busy: result_if.busy_res,
                        done: result_if.done_res, status: result_if.status,
                        sample: result_if.sample, pdwn: result_if.pdwn_level,
                        a0: result_if.a0_level};
                if (expected_pins.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result with nothing predicted: %s", fmt_pins(got));
                end else begin
                    want = expected_pins.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("mismatch on tick %0d", ticks_checked);
                            $display("  expected %s", fmt_pins(want));
                            $display("  actual   %s", fmt_pins(got));
                        end
                    end
                    if (want.done) begin
                        case (want.status)
                            sadc_pkg::ST_TIMEOUT: frames_timeout++;
                            sadc_pkg::ST_ALLONES: frames_allones++;
                            default:              frames_good++;
                        endcase
                    end
                    ticks_checked++;
                    if (ticks_open != 0) ticks_open--;
                end
            end
            result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_tick(input logic start, input logic line);
        pending_ticks.push_back('{start_req: start, dout: line});
        ticks_queued++;
        ticks_open++;
    endtask

    // occasional request while a read is running
    function automatic logic stray_start();
        return ($urandom_range(0, 7) == 0);
    endfunction

    // request followed by a ready line that stays high until timeout
    task automatic queue_timeout();
        queue_tick(1'b1, 1'($urandom_range(0, 1)));
        repeat (cfg_timeout + 1) queue_tick(stray_start(), 1'b1);
    endtask

    // request, ready wait, then a frame aligned to the clock halves (or a ready timeout)
    task automatic queue_read();
        int unsigned      len;
        int unsigned      highs;
        int unsigned      n_ticks;
        int unsigned      bit_idx;
        sadc_pkg::t_frame word;
        bit               garbled;
        len = (cfg_half == '0) ? 1 : cfg_half;
        queue_tick(1'b1, 1'($urandom_range(0, 1)));
        if (cfg_timeout <= 40) highs = $urandom_range(0, cfg_timeout + 2);
        else highs = $urandom_range(0, 6);
        if (cfg_timeout <= 40 && highs > cfg_timeout) begin
            repeat (cfg_timeout + 1) queue_tick(stray_start(), 1'b1);
            return;
        end
        repeat (highs) queue_tick(stray_start(), 1'b1);
        queue_tick(stray_start(), 1'b0);
        // frame word: edge patterns half of the time
        case ($urandom_range(0, 9))
            0: word = '0;
            1: word = '1;
            2: begin
                word = '1;
                word[sadc_pkg::DATA_BITS-1] = 1'b0;
            end
            3: begin
                word = '0;
                word[sadc_pkg::DATA_BITS-1] = 1'b1;
            end
            4: begin
                word = '1;
                word[0] = 1'b0;
            end
            default: word = sadc_pkg::t_frame'({$urandom, $urandom});
        endcase
        garbled = ($urandom_range(0, 7) == 0);
        n_ticks = 2 * len * (sadc_pkg::DATA_BITS + 1);
        for (int unsigned t = 0; t < n_ticks; t++) begin
            bit_idx = t / (2 * len);
            if (bit_idx < sadc_pkg::DATA_BITS && !garbled)
                queue_tick(stray_start(), word[sadc_pkg::DATA_BITS-1-bit_idx]);
            else
                queue_tick(stray_start(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic queue_noise();
        repeat ($urandom_range(1, 6))
            queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // wait for all results, then step the block back to idle if noise left it busy
    task automatic settle();
        while (ticks_open != 0) @(posedge i_clk);
        while (seq_phase != SEQ_IDLE) begin
            queue_tick(1'b0, 1'b0);
            while (ticks_open != 0) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input sadc_pkg::t_cfg_idx idx, input sadc_pkg::t_cfg_dat val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            sadc_pkg::REG_TIMEOUT: cfg_timeout = val[sadc_pkg::WAIT_W-1:0];
            sadc_pkg::REG_HALF:    cfg_half    = val[sadc_pkg::HALF_W-1:0];
            sadc_pkg::REG_POWER:   cfg_power   = val[0];
            sadc_pkg::REG_CHANNEL: cfg_channel = val[0];
            default: ;
        endcase
    endtask

    // program all registers; single-bit registers get random upper data bits
    task automatic set_regs(input logic [sadc_pkg::WAIT_W-1:0] to,
                            input logic [sadc_pkg::HALF_W-1:0] hp,
                            input logic pwr, input logic ch);
        sadc_pkg::t_cfg_dat pwr_word;
        sadc_pkg::t_cfg_dat ch_word;
        pwr_word    = $urandom;
        pwr_word[0] = pwr;
        ch_word     = $urandom;
        ch_word[0]  = ch;
        write_reg(sadc_pkg::REG_TIMEOUT, sadc_pkg::t_cfg_dat'(to));
        write_reg(sadc_pkg::REG_HALF, sadc_pkg::t_cfg_dat'(hp));
        write_reg(sadc_pkg::REG_POWER, pwr_word);
        write_reg(sadc_pkg::REG_CHANNEL, ch_word);
        cfg_if.valid <= 1'b0;
        settings_run++;
    endtask

    task automatic run_phase(input logic [sadc_pkg::WAIT_W-1:0] to,
                             input logic [sadc_pkg::HALF_W-1:0] hp,
                             input logic pwr, input logic ch,
                             input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned n_items, input bit timeouts_only);
        int unsigned first;
        set_regs(to, hp, pwr, ch);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        first = ticks_queued;
        while (ticks_queued - first < n_items) begin
            if (timeouts_only) queue_timeout();
            else if ($urandom_range(0, 9) < 8) queue_read();
            else queue_noise();
        end
        settle();
    endtask

    // stimulus sequence
    initial begin
        item_if.valid     = 1'b0;
        item_if.start_req = 1'b0;
        item_if.dout      = 1'b0;
        result_if.ready   = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = sadc_pkg::REG_TIMEOUT;
        cfg_if.data       = '0;
        i_rst_n           = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle ticks, zero timeout, request while waiting, zero half period
        set_regs('0, '0, 1'b0, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b1);
        queue_tick(1'b1, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b0, 1'b0);
        queue_tick(1'b1, 1'b1);
        queue_tick(1'b1, 1'b0);
        settle();

        // random phases across settings and idling patterns
        run_phase(32'd3, 16'd1, 1'b1, 1'b0, 0, 0, 400, 1'b0);
        run_phase(32'd0, 16'd0, 1'b0, 1'b0, 69, 0, 400, 1'b0);
        run_phase(32'd40, 16'd2, 1'b1, 1'b1, 0, 69, 400, 1'b0);
        run_phase(32'hFFFF_FFFF, 16'd1, 1'b0, 1'b1, 29, 29, 400, 1'b0);
        run_phase(32'd7, 16'hFFFF, 1'b1, 1'b0, 29, 29, 40, 1'b1);
        run_phase(sadc_pkg::RST_TIMEOUT, 16'd3, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 0, 0, 400, 1'b0);

        repeat (10) @(posedge i_clk);
        $display("checked %0d ticks over %0d register settings", ticks_checked, settings_run);
        $display("reads: %0d good frames, %0d ready timeouts, %0d all-ones frames",
                 frames_good, frames_timeout, frames_allones);
        if (mismatch_count == 0 && expected_pins.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("watchdog expired with %0d ticks outstanding", ticks_open);
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
